>>> rtl/irrep_set_product_table_defines.svh
// Assertion helpers used by the controller of the product table block.
`ifndef IRREP_SET_PRODUCT_TABLE_DEFINES_SVH
`define IRREP_SET_PRODUCT_TABLE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define IPT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define IPT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/ipt_pkg.sv
package ipt_pkg;

   localparam int NUM_LABELS  = 8;
   localparam int LABEL_W     = 3;
   localparam int MASK_W      = 8;
   localparam int SCAN_LABELS = (NUM_LABELS < MASK_W) ? NUM_LABELS : MASK_W;
   localparam int TABLE_DEPTH = NUM_LABELS * (NUM_LABELS + 1) / 2;
   localparam int SLOT_W      = $clog2(TABLE_DEPTH);
   localparam int OP_W        = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 8;
   localparam int REQ_TDATA_W = 16;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 16;

   localparam logic [LABEL_W-1:0] LAST_LABEL = LABEL_W'(SCAN_LABELS - 1);

   // Operation codes carried by the request.
   localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_IDENTITY   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VALID_MASK = 1'd1;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [LABEL_W-1:0] label_a;
      logic [LABEL_W-1:0] label_b;
      logic [LABEL_W-1:0] entry_label;
      logic [LABEL_W-1:0] target_label;
      logic               first_item;
      logic               last_item;
   } req_item_type;

   // Table access issued by the sequencer in one cycle.
   typedef struct packed {
      logic              we;
      logic [SLOT_W-1:0] waddr;
      logic [MASK_W-1:0] wdata;
      logic [SLOT_W-1:0] raddr;
   } tbl_req_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_QRY_RD,
      ST_QRY_END,
      ST_RESULT
   } ipt_state_type;

   function automatic logic label_ok(input logic [LABEL_W-1:0] l,
                                     input logic [MASK_W-1:0]  vmask);
      return (int'(l) < NUM_LABELS) && vmask[l];
   endfunction

   function automatic logic [MASK_W-1:0] valid_bits(input logic [MASK_W-1:0] vmask);
      logic [MASK_W-1:0] m;
      m = '0;
      for (int k = 0; k < SCAN_LABELS; k++) begin
         m[k] = label_ok(LABEL_W'(k), vmask);
      end
      return m;
   endfunction

   function automatic logic [MASK_W-1:0] onehot(input logic [LABEL_W-1:0] l);
      return MASK_W'(1) << l;
   endfunction

   // Slot of an unordered pair: hi*(hi+1)/2 + lo.
   function automatic logic [SLOT_W-1:0] slot_of(input logic [LABEL_W-1:0] a,
                                                 input logic [LABEL_W-1:0] b);
      logic [LABEL_W-1:0] lo;
      logic [LABEL_W-1:0] hi;
      int                 s;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      s  = ((int'(hi) * (int'(hi) + 1)) >> 1) + int'(lo);
      return (s < TABLE_DEPTH) ? SLOT_W'(s) : '0;
   endfunction

   // Entry contents after table initialization for the pair lo <= hi.
   function automatic logic [MASK_W-1:0] init_entry(input logic [LABEL_W-1:0] hi,
                                                    input logic [LABEL_W-1:0] lo,
                                                    input logic [LABEL_W-1:0] id,
                                                    input logic [MASK_W-1:0]  vmask);
      logic [MASK_W-1:0] v;
      v = '0;
      if (label_ok(id, vmask)) begin
         if (hi == lo && label_ok(hi, vmask)) begin
            v = v | onehot(id);
         end
         if (lo == id && hi != id && label_ok(hi, vmask)) begin
            v = v | onehot(hi);
         end
         if (hi == id && lo != id && label_ok(lo, vmask)) begin
            v = v | onehot(lo);
         end
      end
      return v;
   endfunction

endpackage

>>> rtl/irrep_set_product_table.sv
// Channel   Dir  Handshake              Payload
// req_      in   req_tvalid/req_tready  req_tdata, req_tuser, req_tlast
// rsp_      out  rsp_tvalid/rsp_tready  rsp_tdata
// csr_      in   csr_we                 csr_index, csr_wdata
//
// Add: accept, table read, table write. Init: the table is swept one entry per cycle.
// A query that folds the set visits the single read port once per label, 8 times,
// then masks the merged set. Any other request returns the block straight to idle.
// A last item then passes through a result state that loads the result register, which
// waits while an earlier result has not been taken; req_tready stays low meanwhile.
// After reset the 36 table entries are swept with req_tready low; csr writes always land.
module irrep_set_product_table (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // label_a [2:0], label_b [5:3], entry_label [8:6], target_label [11:9]
   input  logic [ipt_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // operation [1:0], first_item [2]
   input  logic [ipt_pkg::REQ_TUSER_W-1:0]   req_tuser,
   input  logic                              req_tlast,
   // Result channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // in_product [0], product_mask [8:1]
   output logic [ipt_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // Configuration write port.
   input  logic                              csr_we,
   input  logic [ipt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ipt_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ipt_pkg::*;

   logic [LABEL_W-1:0] identity_ff, identity_in;
   logic [MASK_W-1:0]  valid_mask_ff, valid_mask_in;

   req_item_type       req_item;
   tbl_req_type        tbl_req;
   logic [MASK_W-1:0]  rd_data;
   logic               in_product;
   logic [MASK_W-1:0]  product_mask;

   // Configuration registers; the identity label keeps its low bits only.
   always_comb begin
      identity_in   = identity_ff;
      valid_mask_in = valid_mask_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_IDENTITY:   identity_in   = csr_wdata[LABEL_W-1:0];
            CSR_VALID_MASK: valid_mask_in = csr_wdata[MASK_W-1:0];
            default: begin
               identity_in = identity_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         identity_ff   <= '0;
         valid_mask_ff <= '1;
      end else begin
         identity_ff   <= identity_in;
         valid_mask_ff <= valid_mask_in;
      end
   end

   // Unpack the request into its fields.
   always_comb begin
      req_item.operation    = req_tuser[OP_W-1:0];
      req_item.first_item   = req_tuser[OP_W];
      req_item.label_a      = req_tdata[LABEL_W-1:0];
      req_item.label_b      = req_tdata[2*LABEL_W-1:LABEL_W];
      req_item.entry_label  = req_tdata[3*LABEL_W-1:2*LABEL_W];
      req_item.target_label = req_tdata[4*LABEL_W-1:3*LABEL_W];
      req_item.last_item    = req_tlast;
   end

   ipt_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .identity_label (identity_ff),
      .valid_mask     (valid_mask_ff),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_item       (req_item),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .in_product     (in_product),
      .product_mask   (product_mask),
      .tbl_req        (tbl_req),
      .rd_data        (rd_data)
   );

   ipt_table u_table (
      .clock   (clock),
      .tbl_req (tbl_req),
      .rd_data (rd_data)
   );

   assign rsp_tdata = RSP_TDATA_W'({product_mask, in_product});

endmodule

>>> rtl/ipt_table.sv
module ipt_table (
   input  logic                        clock,
   input  ipt_pkg::tbl_req_type        tbl_req,
   output logic [ipt_pkg::MASK_W-1:0]  rd_data
);
   import ipt_pkg::*;

   logic [MASK_W-1:0] entry_ff [TABLE_DEPTH];
   logic [MASK_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (tbl_req.we) begin
         entry_ff[tbl_req.waddr] <= tbl_req.wdata;
      end
      rd_data_ff <= entry_ff[tbl_req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ipt_ctrl.sv
`include "irrep_set_product_table_defines.svh"

module ipt_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ipt_pkg::LABEL_W-1:0] identity_label,
   input  logic [ipt_pkg::MASK_W-1:0]  valid_mask,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  ipt_pkg::req_item_type       req_item,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        in_product,
   output logic [ipt_pkg::MASK_W-1:0]  product_mask,
   output ipt_pkg::tbl_req_type        tbl_req,
   input  logic [ipt_pkg::MASK_W-1:0]  rd_data
);
   import ipt_pkg::*;

   ipt_state_type     state_ff, state_in;
   req_item_type      item_ff, item_in;
   logic [LABEL_W-1:0] cnt_ff, cnt_in;
   logic [LABEL_W-1:0] hi_ff, hi_in;
   logic [MASK_W-1:0] accum_ff, accum_in;
   logic [MASK_W-1:0] next_ff, next_in;
   logic              pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_prod_ff, rsp_prod_in;
   logic [MASK_W-1:0] rsp_mask_ff, rsp_mask_in;

   logic              accept;
   logic              out_free;
   logic              sweep_last;
   logic              add_ok;
   logic [MASK_W-1:0] rd_merge;

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign sweep_last = (hi_ff == LAST_LABEL) && (cnt_ff == hi_ff);
   assign add_ok     = label_ok(req_item.label_a, valid_mask)
                    && label_ok(req_item.label_b, valid_mask)
                    && label_ok(req_item.entry_label, valid_mask);
   assign rd_merge   = next_ff | (pend_ff ? rd_data : '0);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_item.operation)
                  OP_INIT: state_in = ST_CLEAR;
                  OP_ADD: begin
                     if (add_ok) begin
                        state_in = ST_ADD_RD;
                     end
                  end
                  OP_QUERY: begin
                     if (!req_item.first_item && label_ok(req_item.label_a, valid_mask)) begin
                        state_in = ST_QRY_RD;
                     end else if (req_item.last_item) begin
                        state_in = ST_RESULT;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD_RD:  state_in = ST_ADD_WR;
         ST_ADD_WR:  state_in = ST_IDLE;
         ST_QRY_RD: begin
            if (cnt_ff == LAST_LABEL) begin
               state_in = ST_QRY_END;
            end
         end
         ST_QRY_END: state_in = item_ff.last_item ? ST_RESULT : ST_IDLE;
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath, table port and result register.
   always_comb begin
      item_in      = item_ff;
      cnt_in       = cnt_ff;
      hi_in        = hi_ff;
      accum_in     = accum_ff;
      next_in      = next_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_prod_in  = rsp_prod_ff;
      rsp_mask_in  = rsp_mask_ff;
      tbl_req.we    = 1'b0;
      tbl_req.waddr = slot_of(hi_ff, cnt_ff);
      tbl_req.wdata = init_entry(hi_ff, cnt_ff, identity_label, valid_mask);
      tbl_req.raddr = slot_of(item_ff.label_a, item_ff.label_b);
      unique case (state_ff)
         ST_CLEAR: begin
            tbl_req.we = 1'b1;
            if (sweep_last) begin
               cnt_in = '0;
               hi_in  = '0;
            end else if (cnt_ff == hi_ff) begin
               cnt_in = '0;
               hi_in  = hi_ff + 1'b1;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               item_in = req_item;
               cnt_in  = '0;
               hi_in   = '0;
               next_in = '0;
               pend_in = 1'b0;
               if (req_item.operation == OP_QUERY && req_item.first_item) begin
                  accum_in = label_ok(req_item.label_a, valid_mask)
                           ? onehot(req_item.label_a) : '0;
               end
            end
         end
         ST_ADD_RD: begin
            // Read address already defaults to the pair slot.
         end
         ST_ADD_WR: begin
            tbl_req.we    = 1'b1;
            tbl_req.waddr = slot_of(item_ff.label_a, item_ff.label_b);
            tbl_req.wdata = rd_data | onehot(item_ff.entry_label);
         end
         ST_QRY_RD: begin
            // Read the entry for one member; its data merges in the following cycle.
            tbl_req.raddr = slot_of(item_ff.label_a, cnt_ff);
            pend_in       = accum_ff[cnt_ff] && label_ok(cnt_ff, valid_mask);
            next_in       = rd_merge;
            cnt_in        = (cnt_ff == LAST_LABEL) ? '0 : cnt_ff + 1'b1;
         end
         ST_QRY_END: begin
            accum_in = rd_merge & valid_bits(valid_mask);
            pend_in  = 1'b0;
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_prod_in  = label_ok(item_ff.target_label, valid_mask)
                           && accum_ff[item_ff.target_label];
               rsp_mask_in  = accum_ff;
            end
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         hi_ff        <= '0;
         accum_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         hi_ff        <= hi_in;
         accum_ff     <= accum_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      next_ff     <= next_in;
      rsp_prod_ff <= rsp_prod_in;
      rsp_mask_ff <= rsp_mask_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign in_product   = rsp_prod_ff;
   assign product_mask = rsp_mask_ff;

   `IPT_ASSERT_IMP(a_no_write_in_scan, clock, reset, state_ff == ST_QRY_RD || state_ff == ST_QRY_END, !tbl_req.we, "table written during a product scan")
   `IPT_ASSERT_NXT(a_result_loaded, clock, reset, state_ff == ST_RESULT && out_free, rsp_valid_ff, "result not loaded into the output register")
   `IPT_ASSERT_IMP(a_pend_from_scan, clock, reset, pend_ff, $past(state_ff) == ST_QRY_RD, "pending table data without a scan read")
   `IPT_ASSERT_NXT(a_sweep_ends_idle, clock, reset, state_ff == ST_CLEAR && sweep_last, state_ff == ST_IDLE, "table sweep did not finish in idle")

endmodule

>>> dv/tb_irrep_set_product_table.sv
module tb_irrep_set_product_table;
   timeunit 1ns;
   timeprecision 1ps;

   import ipt_pkg::*;

   // The spare operation code has no meaning; the block must drop it silently.
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

   // Cycles to wait once no result is outstanding. An init request may still
   // be writing the table at that point.
   localparam int HOLD_OFF = 60;
   localparam int RANDOM_REQUESTS = 750;

   // One expected result: membership of the target and the product set.
   typedef struct packed {
      logic              hit;
      logic [MASK_W-1:0] mask;
   } product_type;

   // One row of the directed script. A row either writes a register or sends
   // a request. A pinned row carries its expected result typed in by hand.
   typedef struct {
      bit                    is_csr;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] reg_val;
      req_item_type          rq;
      bit                    pinned;
      logic                  pin_hit;
      logic [MASK_W-1:0]     pin_mask;
   } script_row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // Shadow copy of the block's state and registers, kept by the predictor.
   logic [MASK_W-1:0]  product_table [TABLE_DEPTH];
   logic [MASK_W-1:0]  accum_labels = '0;
   logic [LABEL_W-1:0] cfg_identity = '0;
   logic [MASK_W-1:0]  cfg_valid    = '1;

   product_type    expected_products [$];
   script_row_type script [$];
   product_type    got_want;
   int             mismatches      = 0;
   int             requests_issued = 0;
   int             ready_hold      = 0;
   bit             quiet_phase     = 1'b0;

   irrep_set_product_table uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor of the product table.
   // ---------------------------------------------------------------------

   // A label exists when it is inside the table and enabled in the mask.
   function automatic logic label_live(input logic [LABEL_W-1:0] l);
      return (int'(l) < NUM_LABELS) && cfg_valid[l];
   endfunction

   function automatic logic [MASK_W-1:0] live_set();
      logic [MASK_W-1:0] m;
      m = '0;
      for (int k = 0; k < MASK_W; k++) begin
         m[k] = label_live(LABEL_W'(k));
      end
      return m;
   endfunction

   // Unordered pairs are stored as a triangle: row hi, column lo.
   function automatic int pair_slot(input logic [LABEL_W-1:0] a,
                                    input logic [LABEL_W-1:0] b);
      int lo;
      int hi;
      lo = (a < b) ? int'(a) : int'(b);
      hi = (a < b) ? int'(b) : int'(a);
      return hi * (hi + 1) / 2 + lo;
   endfunction

   // Init: every label times itself gives the identity, and the identity
   // times a label gives that label. With a dead identity the table is empty.
   function automatic void rebuild_table();
      for (int s = 0; s < TABLE_DEPTH; s++) begin
         product_table[s] = '0;
      end
      if (!label_live(cfg_identity)) begin
         return;
      end
      for (int l = 0; l < NUM_LABELS; l++) begin
         if (label_live(LABEL_W'(l))) begin
            product_table[pair_slot(LABEL_W'(l), LABEL_W'(l))][cfg_identity] = 1'b1;
            if (LABEL_W'(l) != cfg_identity) begin
               product_table[pair_slot(cfg_identity, LABEL_W'(l))][l] = 1'b1;
            end
         end
      end
   endfunction

   // Applies one accepted request to the shadow state. Returns 1 when the
   // request produces a result, which is then given in hit and mask.
   function automatic bit predict_request(input req_item_type rq,
                                          output logic hit,
                                          output logic [MASK_W-1:0] mask);
      logic [MASK_W-1:0] merged;
      hit    = 1'b0;
      mask   = '0;
      merged = '0;
      case (rq.operation)
         OP_INIT: begin
            rebuild_table();
            return 1'b0;
         end
         OP_ADD: begin
            if (label_live(rq.label_a) && label_live(rq.label_b) &&
                label_live(rq.entry_label)) begin
               product_table[pair_slot(rq.label_a, rq.label_b)][rq.entry_label] = 1'b1;
            end
            return 1'b0;
         end
         OP_QUERY: ;
         default: return 1'b0;
      endcase
      // A group opens with its own label; each later label folds the set
      // through the table. Members that no longer exist are skipped.
      if (rq.first_item) begin
         accum_labels = label_live(rq.label_a) ? (MASK_W'(1) << rq.label_a) : '0;
      end else if (label_live(rq.label_a)) begin
         for (int m = 0; m < MASK_W; m++) begin
            if (accum_labels[m] && label_live(LABEL_W'(m))) begin
               merged = merged | product_table[pair_slot(rq.label_a, LABEL_W'(m))];
            end
         end
         accum_labels = merged & live_set();
      end
      if (!rq.last_item) begin
         return 1'b0;
      end
      hit  = label_live(rq.target_label) && accum_labels[rq.target_label];
      mask = accum_labels;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------

   // Idle length for either side: mostly none, often a few cycles, rarely a
   // long stretch. A quiet phase runs with no idling at all.
   function automatic int pick_gap();
      int r;
      if (quiet_phase) begin
         return 0;
      end
      r = $urandom_range(99);
      if (r < 60) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(3, 1);
      end
      return $urandom_range(40, 8);
   endfunction

   // Mostly a label that exists under the current mask, sometimes any label.
   function automatic logic [LABEL_W-1:0] pick_label(input int stray_pct);
      logic [LABEL_W-1:0] l;
      l = LABEL_W'($urandom_range(7));
      if ($urandom_range(99) >= stray_pct) begin
         while (!label_live(l)) begin
            l = LABEL_W'($urandom_range(7));
         end
      end
      return l;
   endfunction

   function automatic req_item_type random_item(input logic [OP_W-1:0] op);
      req_item_type rq;
      rq.operation    = op;
      rq.label_a      = LABEL_W'($urandom_range(7));
      rq.label_b      = LABEL_W'($urandom_range(7));
      rq.entry_label  = LABEL_W'($urandom_range(7));
      rq.target_label = LABEL_W'($urandom_range(7));
      rq.first_item   = 1'($urandom_range(1));
      rq.last_item    = 1'($urandom_range(1));
      return rq;
   endfunction

   function automatic script_row_type req_row(input logic [OP_W-1:0] op,
                                              input logic [LABEL_W-1:0] a, b, e, t,
                                              input logic is_first, is_last);
      script_row_type row;
      row.is_csr          = 1'b0;
      row.reg_idx         = '0;
      row.reg_val         = '0;
      row.rq.operation    = op;
      row.rq.label_a      = a;
      row.rq.label_b      = b;
      row.rq.entry_label  = e;
      row.rq.target_label = t;
      row.rq.first_item   = is_first;
      row.rq.last_item    = is_last;
      row.pinned          = 1'b0;
      row.pin_hit         = 1'b0;
      row.pin_mask        = '0;
      return row;
   endfunction

   function automatic script_row_type pin(input script_row_type row, input logic hit,
                                          input logic [MASK_W-1:0] mask);
      row.pinned   = 1'b1;
      row.pin_hit  = hit;
      row.pin_mask = mask;
      return row;
   endfunction

   function automatic script_row_type csr_row(input logic [CSR_IDX_W-1:0] idx,
                                              input logic [CSR_DATA_W-1:0] val);
      script_row_type row;
      row         = req_row(OP_SPARE, '0, '0, '0, '0, 1'b0, 1'b0);
      row.is_csr  = 1'b1;
      row.reg_idx = idx;
      row.reg_val = val;
      return row;
   endfunction

   task automatic flag_mismatch(input string what);
      mismatches++;
      $display("%0t ns: %s", $time, what);
   endtask

   // Drives one request and holds it until the block takes it. The shadow
   // state is updated at the accepting edge. When no gap follows, valid
   // stays high so that the next request goes out back to back.
   task automatic send_request(input req_item_type rq, input bit pinned,
                               input logic pin_hit, input logic [MASK_W-1:0] pin_mask);
      logic              hit;
      logic [MASK_W-1:0] mask;
      product_type       want;
      int                gap;
      req_tdata  <= REQ_TDATA_W'({rq.target_label, rq.entry_label, rq.label_b, rq.label_a});
      req_tuser  <= {rq.first_item, rq.operation};
      req_tlast  <= rq.last_item;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      if (rq.operation != OP_SPARE) begin
         requests_issued++;
      end
      if (predict_request(rq, hit, mask)) begin
         want.hit  = pinned ? pin_hit : hit;
         want.mask = pinned ? pin_mask : mask;
         expected_products.push_back(want);
      end
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops sending, waits for every outstanding result, then gives requests
   // that produce no result time to finish inside the block.
   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (expected_products.size() != 0) @(posedge clock);
      repeat (HOLD_OFF) @(posedge clock);
   endtask

   // Register writes are only issued while the block is idle. The shadow
   // registers follow the write; the table itself is only rebuilt on init.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_IDENTITY) begin
         cfg_identity = val[LABEL_W-1:0];
      end else begin
         cfg_valid = val;
      end
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Result side: random back-pressure and the field-by-field comparison
   // against the oldest expected result.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (expected_products.size() == 0) begin
            flag_mismatch($sformatf("result with none expected, tdata %h", rsp_tdata));
         end else begin
            got_want = expected_products.pop_front();
            if (rsp_tdata[0] !== got_want.hit) begin
               flag_mismatch($sformatf("in_product %b, expected %b",
                                       rsp_tdata[0], got_want.hit));
            end
            if (rsp_tdata[MASK_W:1] !== got_want.mask) begin
               flag_mismatch($sformatf("product_mask %h, expected %h",
                                       rsp_tdata[MASK_W:1], got_want.mask));
            end
         end
      end
      if (ready_hold > 0) begin
         ready_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         ready_hold = pick_gap();
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------
   initial begin
      req_item_type       rq;
      logic [LABEL_W-1:0] ident;
      logic [MASK_W-1:0]  vm;
      int                 phase_len;
      int                 roll;
      int                 group_len;

      // The block comes out of reset with the table built from the reset
      // register values, so the shadow table starts the same way.
      rebuild_table();

      // Directed script. With identity 0 and all labels present, every label
      // squares to label 0 and label 0 times a label gives that label.
      // A last item with no open group folds the empty set left by reset.
      script.push_back(pin(req_row(OP_QUERY, 3'd4, 3'd0, 3'd0, 3'd0, 1'b0, 1'b1),
                           1'b0, 8'h00));
      // A one-item group reports its own label.
      script.push_back(pin(req_row(OP_QUERY, 3'd5, 3'd0, 3'd0, 3'd5, 1'b1, 1'b1),
                           1'b1, 8'h20));
      script.push_back(req_row(OP_QUERY, 3'd3, 3'd0, 3'd0, 3'd0, 1'b1, 1'b0));
      script.push_back(pin(req_row(OP_QUERY, 3'd3, 3'd0, 3'd0, 3'd0, 1'b0, 1'b1),
                           1'b1, 8'h01));
      script.push_back(req_row(OP_QUERY, 3'd0, 3'd0, 3'd0, 3'd0, 1'b1, 1'b0));
      script.push_back(pin(req_row(OP_QUERY, 3'd7, 3'd0, 3'd0, 3'd7, 1'b0, 1'b1),
                           1'b1, 8'h80));
      // The same entry is reached from both label orders.
      script.push_back(req_row(OP_ADD, 3'd2, 3'd5, 3'd7, 3'd0, 1'b0, 1'b0));
      script.push_back(req_row(OP_ADD, 3'd5, 3'd2, 3'd1, 3'd0, 1'b0, 1'b0));
      script.push_back(req_row(OP_QUERY, 3'd2, 3'd0, 3'd0, 3'd0, 1'b1, 1'b0));
      script.push_back(req_row(OP_QUERY, 3'd5, 3'd0, 3'd0, 3'd7, 1'b0, 1'b1));
      script.push_back(req_row(OP_ADD, 3'd7, 3'd7, 3'd7, 3'd7, 1'b1, 1'b1));
      // The spare operation code is dropped even with every flag set.
      script.push_back(req_row(OP_SPARE, 3'd7, 3'd7, 3'd7, 3'd7, 1'b1, 1'b1));
      // Identity moved to the top label and the table rebuilt around it.
      script.push_back(csr_row(CSR_IDENTITY, 8'd7));
      script.push_back(req_row(OP_INIT, 3'd0, 3'd0, 3'd0, 3'd0, 1'b0, 1'b0));
      script.push_back(req_row(OP_QUERY, 3'd2, 3'd0, 3'd0, 3'd0, 1'b1, 1'b0));
      script.push_back(pin(req_row(OP_QUERY, 3'd7, 3'd0, 3'd0, 3'd2, 1'b0, 1'b1),
                           1'b1, 8'h04));
      // Label 7 is removed while the table still names it as a product.
      script.push_back(csr_row(CSR_VALID_MASK, 8'h7F));
      script.push_back(req_row(OP_QUERY, 3'd3, 3'd0, 3'd0, 3'd0, 1'b1, 1'b0));
      script.push_back(pin(req_row(OP_QUERY, 3'd3, 3'd0, 3'd0, 3'd7, 1'b0, 1'b1),
                           1'b0, 8'h00));
      // A group opened with a missing label starts empty.
      script.push_back(pin(req_row(OP_QUERY, 3'd7, 3'd0, 3'd0, 3'd7, 1'b1, 1'b1),
                           1'b0, 8'h00));
      // A missing label later in a group leaves the set alone.
      script.push_back(req_row(OP_QUERY, 3'd1, 3'd0, 3'd0, 3'd0, 1'b1, 1'b0));
      script.push_back(pin(req_row(OP_QUERY, 3'd7, 3'd0, 3'd0, 3'd1, 1'b0, 1'b1),
                           1'b1, 8'h02));
      // An add that names a missing label is ignored.
      script.push_back(req_row(OP_ADD, 3'd7, 3'd1, 3'd2, 3'd0, 1'b0, 1'b0));
      // Init with a missing identity leaves the table empty.
      script.push_back(req_row(OP_INIT, 3'd0, 3'd0, 3'd0, 3'd0, 1'b0, 1'b0));
      script.push_back(req_row(OP_QUERY, 3'd1, 3'd0, 3'd0, 3'd0, 1'b1, 1'b0));
      script.push_back(pin(req_row(OP_QUERY, 3'd1, 3'd0, 3'd0, 3'd1, 1'b0, 1'b1),
                           1'b0, 8'h00));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // The block clears its table after reset with ready held low.
      do @(posedge clock); while (req_tready !== 1'b1);

      foreach (script[i]) begin
         if (script[i].is_csr) begin
            wait_for_idle();
            write_csr(script[i].reg_idx, script[i].reg_val);
         end else begin
            send_request(script[i].rq, script[i].pinned, script[i].pin_hit,
                         script[i].pin_mask);
         end
      end

      // Random phases. Each one starts from an idle block with new register
      // values, including the single-label masks and both identity extremes.
      // Most phases rebuild the table; the others keep entries written under
      // an earlier mask, so stale products get looked up.
      while (requests_issued < RANDOM_REQUESTS) begin
         wait_for_idle();
         quiet_phase = ($urandom_range(3) == 0);
         case ($urandom_range(3))
            0: ident = '0;
            1: ident = '1;
            default: ident = LABEL_W'($urandom_range(7));
         endcase
         case ($urandom_range(5))
            0: vm = 8'hFF;
            1: vm = 8'h01;
            2: vm = 8'h80;
            3: vm = MASK_W'($urandom_range(255, 1)) | MASK_W'($urandom);
            default: vm = MASK_W'($urandom_range(255, 1));
         endcase
         write_csr(CSR_IDENTITY, CSR_DATA_W'(ident));
         write_csr(CSR_VALID_MASK, vm);
         if ($urandom_range(9) < 7) begin
            send_request(random_item(OP_INIT), 1'b0, 1'b0, '0);
         end
         phase_len = $urandom_range(60, 25);
         repeat (phase_len) begin
            roll = $urandom_range(99);
            if (roll < 20) begin
               // Grow the table, mostly with labels that exist.
               rq             = random_item(OP_ADD);
               rq.label_a     = pick_label(10);
               rq.label_b     = pick_label(10);
               rq.entry_label = pick_label(10);
               send_request(rq, 1'b0, 1'b0, '0);
            end else if (roll < 88) begin
               // A well-formed group with random labels, now and then with
               // its opening or closing mark missing.
               group_len = ($urandom_range(7) == 0) ? $urandom_range(8, 5)
                                                    : $urandom_range(4, 1);
               for (int k = 0; k < group_len; k++) begin
                  rq              = random_item(OP_QUERY);
                  rq.label_a      = pick_label(8);
                  rq.target_label = pick_label(15);
                  rq.first_item   = (k == 0) && ($urandom_range(19) != 0);
                  rq.last_item    = (k == group_len - 1) && ($urandom_range(19) != 0);
                  send_request(rq, 1'b0, 1'b0, '0);
               end
            end else begin
               // Noise: any operation code with arbitrary fields.
               send_request(random_item(OP_W'($urandom_range(3))), 1'b0, 1'b0, '0);
            end
         end
      end

      wait_for_idle();
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      #10ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
